// ===== hw/rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants and types for the muxed segment start synchronizer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int MAX_COMPONENTS = 16;
  localparam int SLOT_W         = $clog2(MAX_COMPONENTS);
  localparam int COMP_W         = 4;
  localparam int STAMP_BITS     = 48;
  localparam int DUR_W          = 32;
  localparam int THR_W          = DUR_W + 1;
  localparam int CFG_IDX_W      = 1;
  localparam int DATA_W         = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_COMP = 1'd0,
    CFG_SEG_DUR  = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                  fire;
    logic [COMP_W-1:0]     comp;
    logic                  start;
    logic [STAMP_BITS-1:0] dts;
  } step_t;

  typedef struct packed {
    logic                      mark;
    logic                      is_ref;
    logic [MAX_COMPONENTS-1:0] held;
  } verdict_t;

endpackage

// ===== hw/rtl/muxed_segment_start_sync.sv =====
// ----------------------------------------------------------------------------
// muxed_segment_start_sync
// Segment-start synchronizer for a multiplexed frame descriptor stream.
// ----------------------------------------------------------------------------
// Accepts one frame descriptor per clock unless the output stalls. An input
// register feeds the slot-table decision, whose outcome lands in the result
// register; the slot table is read and updated in the same cycle a frame moves
// there, so consecutive frames on the same component need no spacing. Frames
// before the first marked segment start produce no transfer. Writing the
// reference component clears the table and the synced state; the user must
// write configuration while the stream is idle, which the block does not enforce.
module muxed_segment_start_sync (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: comp_index[3:0], dts[51:4], zero fill[55:52]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mss_pkg::DATA_W-1:0]        in_tdata,
  // in_tuser: seg_start_in[0]
  input  logic                              in_tuser,
  // out_tdata: out_component[3:0], out_dts[51:4], zero fill[55:52]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mss_pkg::DATA_W-1:0]        out_tdata,
  // out_tuser: seg_start_out[0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mss_pkg::DUR_W-1:0]         cfg_data
);

  localparam int PAD_W = mss_pkg::DATA_W - mss_pkg::COMP_W - mss_pkg::STAMP_BITS;

  logic                              s1_valid_r;
  logic [mss_pkg::COMP_W-1:0]        s1_comp_r;
  logic                              s1_start_r;
  logic [mss_pkg::STAMP_BITS-1:0]    s1_dts_r;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [mss_pkg::COMP_W-1:0]        out_comp_r;
  logic [mss_pkg::STAMP_BITS-1:0]    out_dts_r;
  logic                              out_mark_r;

  logic                              synced_r;
  logic                              synced_nxt;
  logic [mss_pkg::COMP_W-1:0]        ref_comp_r;
  logic [mss_pkg::DUR_W-1:0]         seg_dur_r;

  logic                              adv;
  logic                              emit;
  logic                              cfg_fire;
  logic                              cfg_ref_wr;
  mss_pkg::step_t                    step;
  mss_pkg::verdict_t                 verdict;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign cfg_ref_wr = cfg_fire && (cfg_index == mss_pkg::CFG_REF_COMP);

  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;

  assign step.fire  = adv;
  assign step.comp  = s1_comp_r;
  assign step.start = s1_start_r;
  assign step.dts   = s1_dts_r;

  mss_slot_table u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .ref_comp (ref_comp_r),
    .seg_dur  (seg_dur_r),
    .clear    (cfg_ref_wr),
    .verdict  (verdict)
  );

  assign emit = verdict.mark || synced_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    synced_nxt = synced_r;
    if (cfg_ref_wr) begin
      synced_nxt = 1'b0;
    end else if (adv && verdict.mark) begin
      synced_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      synced_r    <= 1'b0;
      ref_comp_r  <= '0;
      seg_dur_r   <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      synced_r    <= synced_nxt;
      if (cfg_ref_wr) begin
        ref_comp_r <= cfg_data[mss_pkg::COMP_W-1:0];
      end
      if (cfg_fire && (cfg_index == mss_pkg::CFG_SEG_DUR)) begin
        seg_dur_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_comp_r  <= in_tdata[mss_pkg::COMP_W-1:0];
      s1_dts_r   <= in_tdata[mss_pkg::COMP_W +: mss_pkg::STAMP_BITS];
      s1_start_r <= in_tuser;
    end
    if (adv) begin
      out_comp_r <= s1_comp_r;
      out_dts_r  <= s1_dts_r;
      out_mark_r <= verdict.mark;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_dts_r, out_comp_r};
  assign out_tuser  = out_mark_r;

  a_mark_syncs: assert property (@(posedge clk) disable iff (!rst_n)
    adv && verdict.mark && !cfg_ref_wr |=> synced_r)
    else $error("segment start did not set synced state");

  a_ref_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && verdict.is_ref |=> verdict.held == '0)
    else $error("reference frame left held slots");

  a_forced_single: assert property (@(posedge clk) disable iff (!rst_n)
    adv && verdict.mark && !verdict.is_ref && !cfg_ref_wr |=> $onehot(verdict.held))
    else $error("forced start left more than one held slot");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_dts_r) && $stable(s1_comp_r))
    else $error("input register lost a stalled frame");

endmodule

// ===== hw/rtl/mss_slot_table.sv =====
// ----------------------------------------------------------------------------
// mss_slot_table
// Per-component held timestamps with valid bits; decides the segment-start
// mark for one frame and updates the table when the frame is retired.
// ----------------------------------------------------------------------------
module mss_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mss_pkg::step_t                step,
  input  logic [mss_pkg::COMP_W-1:0]    ref_comp,
  input  logic [mss_pkg::DUR_W-1:0]     seg_dur,
  input  logic                          clear,
  output mss_pkg::verdict_t             verdict
);

  logic [mss_pkg::MAX_COMPONENTS-1:0] held_valid_r;
  logic [mss_pkg::MAX_COMPONENTS-1:0] held_valid_nxt;
  logic [mss_pkg::STAMP_BITS-1:0]     held_stamp_r [mss_pkg::MAX_COMPONENTS];

  logic [mss_pkg::SLOT_W-1:0]         idx;
  logic                               is_ref;
  logic                               has_slot;
  logic [mss_pkg::STAMP_BITS-1:0]     old_stamp;
  logic [mss_pkg::STAMP_BITS:0]       diff;
  logic [mss_pkg::THR_W-1:0]          thr;
  logic                               late;
  logic                               forced;
  logic                               wr_stamp;
  logic [mss_pkg::MAX_COMPONENTS-1:0] sel;

  always_comb begin
    idx       = mss_pkg::SLOT_W'(step.comp);
    is_ref    = (step.comp == ref_comp);
    has_slot  = (32'(step.comp) < mss_pkg::MAX_COMPONENTS);
    old_stamp = held_valid_r[idx] ? held_stamp_r[idx] : step.dts;
    diff      = {1'b0, step.dts} - {1'b0, old_stamp};
    thr       = {seg_dur, 1'b0};
    late      = !diff[mss_pkg::STAMP_BITS] &&
                (diff[mss_pkg::STAMP_BITS-1:0] >= mss_pkg::STAMP_BITS'(thr));
    forced    = step.start && !is_ref && has_slot && late;
    sel       = mss_pkg::MAX_COMPONENTS'(1) << idx;
    wr_stamp  = step.fire && !is_ref && has_slot && (!held_valid_r[idx] || forced);

    held_valid_nxt = held_valid_r;
    if (step.fire) begin
      if (is_ref) begin
        held_valid_nxt = '0;
      end else if (forced) begin
        held_valid_nxt = sel;
      end else if (has_slot) begin
        held_valid_nxt = held_valid_r | sel;
      end
    end
    if (clear) begin
      held_valid_nxt = '0;
    end

    verdict.mark   = step.start && (is_ref || forced);
    verdict.is_ref = is_ref;
    verdict.held   = held_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_stamp) begin
      held_stamp_r[idx] <= step.dts;
    end
  end

endmodule
